@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define VRM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define VRM_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define VRM_ASSERT(lbl, clk, rstn, prop)
`define VRM_ASSERT_NR(lbl, clk, prop)
`endif

`endif

@@ rtl/core/vrm_pkg.sv @@
`default_nettype none
package vrm_pkg;

  localparam int unsigned GridXDef    = 32;
  localparam int unsigned GridYDef    = 32;
  localparam int unsigned GridZDef    = 16;
  localparam int unsigned MaxStepsDef = 128;

  localparam int unsigned PosW   = 20;
  localparam int unsigned CellW  = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW   = 9;

  localparam logic [CfgIdxW-1:0] RegSizeX     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSizeY     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSizeZ     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegEdgeWidth = 3'd3;
  localparam logic [CfgIdxW-1:0] RegEmptyCode = 3'd4;
  localparam logic [CfgIdxW-1:0] RegEdgeCode  = 3'd5;

  localparam logic [5:0] SizeXRst     = 6'd20;
  localparam logic [5:0] SizeYRst     = 6'd20;
  localparam logic [4:0] SizeZRst     = 5'd10;
  localparam logic [8:0] EdgeWidthRst = 9'd31;
  localparam logic [7:0] EmptyCodeRst = 8'd32;
  localparam logic [7:0] EdgeCodeRst  = 8'd46;
  localparam logic [7:0] StoreRstCode = 8'd32;

  localparam logic       OpWrite = 1'b0;
  localparam logic       OpTrace = 1'b1;

  localparam logic [15:0] DirMin  = 16'd164;
  localparam logic [11:0] StepCap = 12'd2048;
  localparam logic [11:0] StepEps = 12'd10;
  localparam logic [10:0] FracOne = 11'd1024;

  typedef struct packed {
    logic              opcode;
    logic [4:0]        cell_x;
    logic [4:0]        cell_y;
    logic [3:0]        cell_z;
    logic [7:0]        cell_code;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic signed [15:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic [7:0]        result_code;
    logic              on_edge;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic signed [15:0] end_z;
  } out_item_t;

endpackage
`default_nettype wire

@@ rtl/core/voxel_ray_march.sv @@
// Channel  Dir  Signals                              Item
// in       in   in_valid_i, in_stall_o, in_data_i    write cell / trace ray
// out      out  out_valid_o, out_stall_i, out_data_o one result per item
// cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i      register write
// A write item returns an all-zero result. A trace takes per cell a read and a
// test (S_CHECK, S_READ), per axis a setup step (S_DSETUP) plus a divider run
// (S_DSTEP) when the axis counts, and a multiply and an add per axis to move;
// at most MAX_STEPS cells, each one's time set mainly by the shared restoring divider.
// After reset the store is swept to spaces, one cell per cycle, in_stall_o high.
// One item at a time: in_stall_o stays high while an item runs or a result waits.
`default_nettype none
`include "assert_macros.svh"
module voxel_ray_march #(
  parameter int unsigned GRID_X    = vrm_pkg::GridXDef,
  parameter int unsigned GRID_Y    = vrm_pkg::GridYDef,
  parameter int unsigned GRID_Z    = vrm_pkg::GridZDef,
  parameter int unsigned MAX_STEPS = vrm_pkg::MaxStepsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  vrm_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output vrm_pkg::out_item_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [vrm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [vrm_pkg::CfgW-1:0]      cfg_data_i
);
  import vrm_pkg::*;

  localparam int unsigned Depth = GRID_X * GRID_Y * GRID_Z;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned NW    = $clog2(MAX_STEPS + 1);
  localparam int unsigned LinW  = 20;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_READ, S_DSETUP, S_DSTEP, S_MUL, S_ADD
  } state_e;

  state_e state_q;

  logic [5:0] size_x_q, size_y_q;
  logic [4:0] size_z_q;
  logic [8:0] edge_width_q;
  logic [7:0] empty_code_q, edge_code_q;

  logic signed [PosW-1:0] pos_q [3];
  logic signed [15:0]     dir_q [3];
  logic [1:0]             axis_q;
  logic [NW-1:0]          step_n_q;
  logic [11:0]            best_q;
  logic [24:0]            rem_q;
  logic [25:0]            dvs_q;
  logic [10:0]            quo_q;
  logic [3:0]             dcnt_q;
  logic [27:0]            prod_q;
  logic [AW-1:0]          clr_q;

  logic      out_valid_q;
  out_item_t out_q;

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;

  // ---- helpers
  function automatic logic [15:0] mag16(input logic signed [15:0] d);
    mag16 = d[15] ? 16'(-d) : d;
  endfunction

  function automatic logic near_int(input logic signed [PosW-1:0] p,
                                    input logic [8:0] ew);
    logic [10:0] f, g, m;
    f = {1'b0, p[9:0]};
    g = FracOne - f;
    m = (f < g) ? f : g;
    near_int = m < {2'b0, ew};
  endfunction

  function automatic logic [15:0] sat16(input logic signed [PosW-1:0] p);
    if (p > PosW'(signed'(32767)))       sat16 = 16'h7fff;
    else if (p < -PosW'(signed'(32768))) sat16 = 16'h8000;
    else                                 sat16 = p[15:0];
  endfunction

  // ---- grid limits and cell address
  logic [6:0]  lim_x, lim_y, lim_z;
  logic [16:0] lx, ly, lz;
  logic        in_grid;
  logic [LinW-1:0] cell_lin, wr_lin;
  logic        wr_ok;

  always_comb begin
    lim_x = ({1'b0, size_x_q} < 7'(GRID_X)) ? {1'b0, size_x_q} : 7'(GRID_X);
    lim_y = ({1'b0, size_y_q} < 7'(GRID_Y)) ? {1'b0, size_y_q} : 7'(GRID_Y);
    lim_z = ({2'b0, size_z_q} < 7'(GRID_Z)) ? {2'b0, size_z_q} : 7'(GRID_Z);
    lx = {lim_x, 10'b0};
    ly = {lim_y, 10'b0};
    lz = {lim_z, 10'b0};
    in_grid = !pos_q[0][PosW-1] && !pos_q[1][PosW-1] && !pos_q[2][PosW-1] &&
              (pos_q[0][PosW-2:0] < (PosW-1)'(lx)) &&
              (pos_q[1][PosW-2:0] < (PosW-1)'(ly)) &&
              (pos_q[2][PosW-2:0] < (PosW-1)'(lz));
    cell_lin = LinW'(pos_q[2][10+CellW-1:10]) * LinW'(GRID_X * GRID_Y) +
               LinW'(pos_q[1][10+CellW-1:10]) * LinW'(GRID_X) +
               LinW'(pos_q[0][10+CellW-1:10]);
    wr_lin   = LinW'(in_data_i.cell_z) * LinW'(GRID_X * GRID_Y) +
               LinW'(in_data_i.cell_y) * LinW'(GRID_X) +
               LinW'(in_data_i.cell_x);
    wr_ok    = (32'(in_data_i.cell_x) < GRID_X) && (32'(in_data_i.cell_y) < GRID_Y) &&
               (32'(in_data_i.cell_z) < GRID_Z);
  end

  logic in_acc;
  assign in_stall_o = (state_q != S_IDLE) || out_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = cell_lin[AW-1:0];
    mem_wdata = in_data_i.cell_code;
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_addr  = clr_q;
      mem_wdata = StoreRstCode;
    end else if (in_acc && in_data_i.opcode == OpWrite) begin
      mem_we   = wr_ok;
      mem_addr = wr_lin[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem[mem_addr];
  end

  // ---- per-axis values for the divider and mover
  logic [15:0] cur_mag;
  logic [9:0]  cur_f;
  logic [10:0] cur_num;
  logic        dbit;
  logic [24:0] rem_nx;
  logic [10:0] quo_nx;
  logic [11:0] step_len;
  logic [13:0] delta;
  logic [1:0]  near_cnt;

  always_comb begin
    cur_mag  = mag16(dir_q[axis_q]);
    cur_f    = pos_q[axis_q][9:0];
    cur_num  = dir_q[axis_q][15] ? {1'b0, cur_f} : (FracOne - {1'b0, cur_f});
    dbit     = {1'b0, rem_q} >= dvs_q;
    rem_nx   = dbit ? 25'({1'b0, rem_q} - dvs_q) : rem_q;
    quo_nx   = {quo_q[9:0], dbit};
    step_len = best_q + StepEps;
    delta    = prod_q[27:14];
    near_cnt = 2'(near_int(pos_q[0], edge_width_q)) + 2'(near_int(pos_q[1], edge_width_q)) +
               2'(near_int(pos_q[2], edge_width_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
      axis_q       <= '0;
      step_n_q     <= '0;
      dcnt_q       <= '0;
      size_x_q     <= SizeXRst;
      size_y_q     <= SizeYRst;
      size_z_q     <= SizeZRst;
      edge_width_q <= EdgeWidthRst;
      empty_code_q <= EmptyCodeRst;
      edge_code_q  <= EdgeCodeRst;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegSizeX:     size_x_q     <= cfg_data_i[5:0];
          RegSizeY:     size_y_q     <= cfg_data_i[5:0];
          RegSizeZ:     size_z_q     <= cfg_data_i[4:0];
          RegEdgeWidth: edge_width_q <= cfg_data_i;
          RegEmptyCode: empty_code_q <= cfg_data_i[7:0];
          RegEdgeCode:  edge_code_q  <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (32'(clr_q) == Depth - 1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            if (in_data_i.opcode == OpWrite) begin
              out_q       <= '0;
              out_valid_q <= 1'b1;
            end else begin
              pos_q[0] <= PosW'(in_data_i.origin_x);
              pos_q[1] <= PosW'(in_data_i.origin_y);
              pos_q[2] <= PosW'(in_data_i.origin_z);
              dir_q[0] <= in_data_i.dir_x;
              dir_q[1] <= in_data_i.dir_y;
              dir_q[2] <= in_data_i.dir_z;
              step_n_q <= '0;
              state_q  <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (32'(step_n_q) == MAX_STEPS || !in_grid) begin
            out_q.hit         <= 1'b0;
            out_q.result_code <= empty_code_q;
            out_q.on_edge     <= 1'b0;
            out_q.end_x       <= sat16(pos_q[0]);
            out_q.end_y       <= sat16(pos_q[1]);
            out_q.end_z       <= sat16(pos_q[2]);
            out_valid_q       <= 1'b1;
            state_q           <= S_IDLE;
          end else begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          if (rdata_q != empty_code_q) begin
            out_q.hit         <= 1'b1;
            out_q.on_edge     <= near_cnt >= 2'd2;
            out_q.result_code <= (near_cnt >= 2'd2) ? edge_code_q : rdata_q;
            out_q.end_x       <= sat16(pos_q[0]);
            out_q.end_y       <= sat16(pos_q[1]);
            out_q.end_z       <= sat16(pos_q[2]);
            out_valid_q       <= 1'b1;
            state_q           <= S_IDLE;
          end else begin
            best_q  <= StepCap;
            axis_q  <= '0;
            state_q <= S_DSETUP;
          end
        end
        S_DSETUP: begin
          if (cur_mag < DirMin || {2'b0, cur_num, 14'b0} >= {cur_mag, 11'b0}) begin
            axis_q  <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
            state_q <= (axis_q == 2'd2) ? S_MUL : S_DSETUP;
          end else begin
            rem_q   <= {cur_num, 14'b0};
            dvs_q   <= {cur_mag, 10'b0};
            quo_q   <= '0;
            dcnt_q  <= 4'd10;
            state_q <= S_DSTEP;
          end
        end
        S_DSTEP: begin
          rem_q  <= rem_nx;
          quo_q  <= quo_nx;
          dvs_q  <= dvs_q >> 1;
          dcnt_q <= dcnt_q - 4'd1;
          if (dcnt_q == 4'd0) begin
            if ({1'b0, quo_nx} < best_q) begin
              best_q <= {1'b0, quo_nx};
            end
            axis_q  <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
            state_q <= (axis_q == 2'd2) ? S_MUL : S_DSETUP;
          end
        end
        S_MUL: begin
          prod_q  <= 28'(step_len) * 28'(cur_mag);
          state_q <= S_ADD;
        end
        S_ADD: begin
          pos_q[axis_q] <= dir_q[axis_q][15] ? pos_q[axis_q] - PosW'(delta)
                                             : pos_q[axis_q] + PosW'(delta);
          if (axis_q == 2'd2) begin
            axis_q   <= '0;
            step_n_q <= step_n_q + 1'b1;
            state_q  <= S_CHECK;
          end else begin
            axis_q  <= axis_q + 2'd1;
            state_q <= S_MUL;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `VRM_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_acc |=> in_stall_o)
  `VRM_ASSERT(a_clear_stalls, clk_i, rst_ni, (state_q == S_CLEAR) |-> in_stall_o)
  `VRM_ASSERT(a_step_bound, clk_i, rst_ni, 32'(step_n_q) <= MAX_STEPS)
  `VRM_ASSERT(a_div_count, clk_i, rst_ni, (state_q == S_DSTEP) |-> (dcnt_q <= 4'd10))
  `VRM_ASSERT(a_axis_range, clk_i, rst_ni, axis_q != 2'd3)

endmodule
`default_nettype wire

@@ verif/tb_voxel_ray_march.sv @@
`default_nettype none
module tb_voxel_ray_march;
  timeunit 1ns;
  timeprecision 1ps;
  import vrm_pkg::*;

  localparam int GX = 32;
  localparam int GY = 32;
  localparam int GZ = 16;
  localparam int STEPS_MAX = 128;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = RegSizeX;
  logic [CfgW-1:0] cfg_data = '0;

  voxel_ray_march DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  in_item_t pend_q[$];
  out_item_t result_q[$];
  logic [7:0] voxels[GX*GY*GZ];
  int lim_x = 20, lim_y = 20, lim_z = 10, edge_w = 31, empty_c = 32, edge_c = 46;
  int errors = 0;
  int acc_cnt = 0;
  int res_cnt = 0;
  bit burst = 1'b0;
  bit hold_req = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  function automatic int march_axis(input int p, input int d, input int best);
    int f, mag, num, t;
    f = p & 1023;
    mag = d < 0 ? -d : d;
    if (mag < 164) return best;
    num = d > 0 ? 1024 - f : f;
    t = (num * 16384) / mag;
    return t < best ? t : best;
  endfunction

  function automatic int move_axis(input int p, input int d, input int step);
    int mag, delta;
    mag = d < 0 ? -d : d;
    delta = (step * mag) >>> 14;
    return d < 0 ? p - delta : p + delta;
  endfunction

  function automatic bit near_grid(input int p);
    int f, m;
    f = p & 1023;
    m = f < 1024 - f ? f : 1024 - f;
    return m < edge_w;
  endfunction

  function automatic logic [15:0] clamp16(input int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic out_item_t trace_ray(input in_item_t it);
    out_item_t r;
    int px, py, pz, dx, dy, dz, lx, ly, lz, step, cnt;
    logic [7:0] c;
    r = '0;
    if (it.opcode == OpWrite) begin
      voxels[(int'(it.cell_z) * GY + int'(it.cell_y)) * GX + int'(it.cell_x)] = it.cell_code;
      return r;
    end
    px = int'(it.origin_x); py = int'(it.origin_y); pz = int'(it.origin_z);
    dx = int'(it.dir_x); dy = int'(it.dir_y); dz = int'(it.dir_z);
    lx = (lim_x < GX ? lim_x : GX) * 1024;
    ly = (lim_y < GY ? lim_y : GY) * 1024;
    lz = (lim_z < GZ ? lim_z : GZ) * 1024;
    r.result_code = empty_c[7:0];
    for (int n = 0; n < STEPS_MAX; n++) begin
      if (px < 0 || py < 0 || pz < 0 || px >= lx || py >= ly || pz >= lz) break;
      c = voxels[((pz >>> 10) * GY + (py >>> 10)) * GX + (px >>> 10)];
      if (c != empty_c[7:0]) begin
        cnt = int'(near_grid(px)) + int'(near_grid(py)) + int'(near_grid(pz));
        r.hit = 1'b1;
        if (cnt >= 2) begin
          r.on_edge = 1'b1;
          r.result_code = edge_c[7:0];
        end else begin
          r.result_code = c;
        end
        break;
      end
      step = 2048;
      step = march_axis(px, dx, step);
      step = march_axis(py, dy, step);
      step = march_axis(pz, dz, step);
      step += 10;
      px = move_axis(px, dx, step);
      py = move_axis(py, dy, step);
      pz = move_axis(pz, dz, step);
    end
    r.end_x = clamp16(px);
    r.end_y = clamp16(py);
    r.end_z = clamp16(pz);
    return r;
  endfunction

  // input driver
  int sent_cnt = 0;
  int in_gap = 0;
  always @(negedge clk) begin
    logic nv;
    nv = in_valid;
    if (in_valid && acc_cnt == sent_cnt) begin
      nv = 1'b0;
      in_gap = burst ? 0 : $urandom_range(0, 10);
    end
    if (!nv && rst_n) begin
      if (in_gap > 0) in_gap--;
      else if (pend_q.size() > 0) begin
        nv = 1'b1;
        in_data <= pend_q.pop_front();
        sent_cnt++;
      end
    end
    in_valid <= nv;
  end

  // result receiver
  int out_wait = 0;
  int seen_res = 0;
  bit hold_done = 1'b0;
  always @(negedge clk) begin
    if (seen_res != res_cnt) begin
      seen_res = res_cnt;
      out_wait = burst ? 0 : $urandom_range(0, 10);
    end
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      out_wait = 3000;
    end
    if (out_wait > 0) begin
      out_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t w;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        result_q.push_back(trace_ray(in_data));
        acc_cnt++;
      end
      if (out_valid && !out_stall) begin
        res_cnt++;
        if (result_q.size() == 0) begin
          report("unexpected item", 0, 0);
        end else begin
          w = result_q.pop_front();
          if (out_data.hit !== w.hit) report("hit", int'(out_data.hit), int'(w.hit));
          if (out_data.result_code !== w.result_code)
            report("result_code", int'(out_data.result_code), int'(w.result_code));
          if (out_data.on_edge !== w.on_edge)
            report("on_edge", int'(out_data.on_edge), int'(w.on_edge));
          if (out_data.end_x !== w.end_x) report("end_x", int'(out_data.end_x), int'(w.end_x));
          if (out_data.end_y !== w.end_y) report("end_y", int'(out_data.end_y), int'(w.end_y));
          if (out_data.end_z !== w.end_z) report("end_z", int'(out_data.end_z), int'(w.end_z));
        end
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val[CfgW-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegSizeX: lim_x = val & 63;
      RegSizeY: lim_y = val & 63;
      RegSizeZ: lim_z = val & 31;
      RegEdgeWidth: edge_w = val & 511;
      RegEmptyCode: empty_c = val & 255;
      RegEdgeCode: edge_c = val & 255;
      default: ;
    endcase
  endtask

  task automatic set_regs(input int sx, sy, sz, ew, ec, gc);
    write_reg(RegSizeX, sx);
    write_reg(RegSizeY, sy);
    write_reg(RegSizeZ, sz);
    write_reg(RegEdgeWidth, ew);
    write_reg(RegEmptyCode, ec);
    write_reg(RegEdgeCode, gc);
  endtask

  task automatic drain();
    while (pend_q.size() > 0 || in_valid || result_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic in_item_t noise_item();
    in_item_t it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  function automatic in_item_t cell_write(input int x, y, z, code);
    in_item_t it;
    it = noise_item();
    it.opcode = OpWrite;
    it.cell_x = 5'(x); it.cell_y = 5'(y); it.cell_z = 4'(z); it.cell_code = 8'(code);
    return it;
  endfunction

  function automatic in_item_t ray(input int ox, oy, oz, dx, dy, dz);
    in_item_t it;
    it = noise_item();
    it.opcode = OpTrace;
    it.origin_x = 16'(ox); it.origin_y = 16'(oy); it.origin_z = 16'(oz);
    it.dir_x = 16'(dx); it.dir_y = 16'(dy); it.dir_z = 16'(dz);
    return it;
  endfunction

  function automatic int rand_dir();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 327) - 163;
      1: return $signed(16'($urandom));
      default: return $urandom_range(0, 32768) - 16384;
    endcase
  endfunction

  function automatic int rand_org(input int lim);
    int l;
    l = lim < 1 ? 1 : (lim > 32 ? 32 : lim);
    if ($urandom_range(0, 9) == 0) return $signed(16'($urandom));
    return $urandom_range(0, l * 1024 - 1);
  endfunction

  function automatic in_item_t rand_item();
    int dx, dy, dz;
    if ($urandom_range(0, 9) < 4) begin
      return cell_write($urandom_range(0, lim_x > 32 ? 31 : (lim_x < 1 ? 0 : lim_x - 1)),
                        $urandom_range(0, lim_y > 32 ? 31 : (lim_y < 1 ? 0 : lim_y - 1)),
                        $urandom_range(0, lim_z > 16 ? 15 : (lim_z < 1 ? 0 : lim_z - 1)),
                        $urandom_range(0, 3) == 0 ? empty_c : $urandom_range(0, 255));
    end
    dx = rand_dir(); dy = rand_dir(); dz = rand_dir();
    if ($urandom_range(0, 3) == 0) begin
      dx = 0; dy = 0; dz = 0;
      case ($urandom_range(0, 2))
        0: dx = $urandom_range(0, 1) ? 16384 : -16384;
        1: dy = $urandom_range(0, 1) ? 16384 : -16384;
        default: dz = $urandom_range(0, 1) ? 16384 : -16384;
      endcase
    end
    if ($urandom_range(0, 40) == 0) begin
      dx = 0; dy = 0; dz = 0;
    end
    return ray(rand_org(lim_x), rand_org(lim_y), rand_org(lim_z), dx, dy, dz);
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) pend_q.push_back(rand_item());
  endtask

  initial begin
    for (int i = 0; i < GX*GY*GZ; i++) voxels[i] = 8'd32;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed
    pend_q.push_back(cell_write(31, 31, 15, 255));
    pend_q.push_back(cell_write(0, 0, 0, 0));
    pend_q.push_back(cell_write(5, 3, 2, 65));
    pend_q.push_back(cell_write(19, 19, 9, 66));
    pend_q.push_back(ray(512, 512, 512, 0, 0, 0));
    pend_q.push_back(ray(1024, 1024, 1024, -16384, -16384, -16384));
    pend_q.push_back(ray(500, 3500, 2500, 16384, 0, 0));
    pend_q.push_back(ray(-1, 100, 100, 16384, 0, 0));
    pend_q.push_back(ray(32767, 32767, 32767, -32768, -32768, -32768));
    pend_q.push_back(ray(-32768, -32768, -32768, 32767, 32767, 32767));
    pend_q.push_back(ray(19500, 19500, 9300, 16384, 16384, 16384));
    pend_q.push_back(ray(10000, 10000, 5000, 163, -163, 100));
    pend_q.push_back(ray(5120, 3072, 2560, 100, 16384, -164));
    pend_q.push_back(ray(20479, 200, 200, 16384, 0, 0));
    pend_q.push_back(ray(100, 100, 100, 9459, 9459, 9459));
    drain();

    set_regs(32, 32, 16, 0, 32, 255);
    run_random(140);
    drain();

    set_regs(1, 1, 1, 511, 0, 0);
    pend_q.push_back(ray(512, 512, 512, 0, 16384, 0));
    pend_q.push_back(ray(10, 1000, 10, 1000, 1000, 1000));
    run_random(50);
    drain();

    set_regs(0, 40, 17, 100, 32, 46);
    pend_q.push_back(ray(512, 512, 512, 16384, 0, 0));
    run_random(30);
    drain();

    set_regs($urandom_range(5, 32), $urandom_range(5, 32), $urandom_range(5, 16),
             $urandom_range(0, 511), 32, $urandom_range(0, 255));
    run_random(40);
    hold_req = 1'b1;
    run_random(110);
    drain();

    burst = 1'b1;
    set_regs(32, 32, 16, 31, 32, 46);
    run_random(100);
    drain();
    burst = 1'b0;
    run_random(80);
    drain();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
